@@ sv/fcsa_pkg.sv @@
// Shared types and constants for the frustum culling unit.
// No dependencies; imported by the top level and the checker.
package fcsa_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 3;
  localparam int PROD_W  = 2 * VALUE_W;
  // Three 64-bit products plus two scaled 32-bit terms fit with margin in 67 bits.
  localparam int SUM_W   = 67;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_NONE   = 2'd3
  } command_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] nx;
    logic signed [VALUE_W-1:0] ny;
    logic signed [VALUE_W-1:0] nz;
    logic signed [VALUE_W-1:0] offset;
  } plane_t;

  localparam int PLANE_W = $bits(plane_t);

endpackage

@@ sv/frustum_cull_sphere_aabb.sv @@
// Frustum culling unit: plane store in one RAM, sphere and two-corner box tests.
// Depends on fcsa_pkg and fcsa_ram.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready | command, plane_index, value_a..value_f
//   out     | output    | out_valid/out_ready | inside_res
//
// A load writes the plane into the RAM on its transfer, and the block is ready again
// in the next cycle. A test does one RAM read per plane, then passes through the
// multiply, partial sum and sign stages of the shared dot-product lanes before its
// result sits in the output register.
// Reset clears the control state and the output valid; the plane RAM is not cleared.
// A result waiting on out_ready does not block new items; a finished test holds in its
// last state until the output register is free.
module frustum_cull_sphere_aabb #(
  parameter int PLANE_COUNT = 6,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fcsa_pkg::CMD_W-1:0]           command,
  input  logic [fcsa_pkg::INDEX_W-1:0]         plane_index,
  input  logic signed [fcsa_pkg::VALUE_W-1:0]  value_a,
  input  logic signed [fcsa_pkg::VALUE_W-1:0]  value_b,
  input  logic signed [fcsa_pkg::VALUE_W-1:0]  value_c,
  input  logic signed [fcsa_pkg::VALUE_W-1:0]  value_d,
  input  logic signed [fcsa_pkg::VALUE_W-1:0]  value_e,
  input  logic signed [fcsa_pkg::VALUE_W-1:0]  value_f,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 inside_res
);

  import fcsa_pkg::*;

  localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PLANE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  // Input transfer decode
  logic in_xfer;
  logic load_we;
  logic test_start;

  assign in_ready   = (state == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign load_we    = in_xfer && (command_t'(command) == CMD_LOAD)
                      && (int'(plane_index) < PLANE_COUNT);
  assign test_start = in_xfer && ((command_t'(command) == CMD_SPHERE)
                      || (command_t'(command) == CMD_BOX));

  // Test operands, held for the whole test
  logic                      is_sphere;
  logic signed [VALUE_W-1:0] op_a, op_b, op_c, op_d, op_e, op_f;

  // Plane RAM. Loads only happen in idle, so a test never reads an entry in flight.
  plane_t           wr_plane;
  plane_t           rd_plane;
  logic [PLANE_W-1:0] rd_word;
  logic [IDX_W-1:0] rd_idx;

  assign wr_plane = '{nx: value_a, ny: value_b, nz: value_c, offset: value_d};
  assign rd_plane = plane_t'(rd_word);

  fcsa_ram #(
    .WIDTH  (PLANE_W),
    .DEPTH  (PLANE_COUNT),
    .ADDR_W (IDX_W)
  ) u_plane_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (plane_index[IDX_W-1:0]),
    .wdata (PLANE_W'(wr_plane)),
    .raddr (rd_idx),
    .rdata (rd_word)
  );

  // Pipeline control: v1 = RAM data valid, v2 = products valid, v3 = partial sums valid
  logic v1, v2, v3;
  logic l1, l2, l3;

  // Lane A: sphere centre or box min corner. Lane B: box max corner.
  logic signed [PROD_W-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
  logic signed [SUM_W-1:0]  off_term, ext_term;
  logic signed [SUM_W-1:0]  sa_lo, sa_hi, sb_lo, sb_hi;
  logic signed [SUM_W-1:0]  tot_a, tot_b;
  logic                     plane_reject;
  logic                     reject_acc;

  assign tot_a        = sa_lo + sa_hi;
  assign tot_b        = sb_lo + sb_hi;
  // Sphere: reject on the one signed distance. Box: reject when both corners are below.
  assign plane_reject = is_sphere ? tot_a[SUM_W-1] : (tot_a[SUM_W-1] && tot_b[SUM_W-1]);

  // Hold operands for the test
  always_ff @(posedge clk) begin
    if (test_start) begin
      is_sphere <= (command_t'(command) == CMD_SPHERE);
      op_a      <= value_a;
      op_b      <= value_b;
      op_c      <= value_c;
      op_d      <= value_d;
      op_e      <= value_e;
      op_f      <= value_f;
    end
  end

  // Datapath stages: no stall inside a test, so stages advance every cycle
  always_ff @(posedge clk) begin
    pa_x     <= rd_plane.nx * op_a;
    pa_y     <= rd_plane.ny * op_b;
    pa_z     <= rd_plane.nz * op_c;
    pb_x     <= rd_plane.nx * op_d;
    pb_y     <= rd_plane.ny * op_e;
    pb_z     <= rd_plane.nz * op_f;
    off_term <= SUM_W'(rd_plane.offset) <<< FRAC_BITS;
    ext_term <= is_sphere ? (SUM_W'(op_d) <<< FRAC_BITS) : '0;

    sa_lo <= SUM_W'(pa_x) + SUM_W'(pa_y);
    sa_hi <= SUM_W'(pa_z) + off_term + ext_term;
    sb_lo <= SUM_W'(pb_x) + SUM_W'(pb_y);
    sb_hi <= SUM_W'(pb_z) + off_term;
  end

  // Pipeline valids and reject accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      l1         <= 1'b0;
      l2         <= 1'b0;
      l3         <= 1'b0;
      reject_acc <= 1'b0;
    end else begin
      v1 <= (state == ST_RUN);
      l1 <= (state == ST_RUN) && (rd_idx == LAST_IDX);
      v2 <= v1;
      l2 <= l1;
      v3 <= v2;
      l3 <= l2;
      if (test_start) begin
        reject_acc <= 1'b0;
      end else if (v3) begin
        reject_acc <= reject_acc | plane_reject;
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_idx     <= '0;
      out_valid  <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      // Finish refills the output register itself, so clear only outside it
      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (test_start) begin
            rd_idx <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (rd_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (v3 && l3) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Drop the result into the output register once it is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            inside_res <= !reject_acc;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/fcsa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module fcsa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fcsa_checker.sv @@
// Port-level checker for the frustum culling unit, bound to the top level.
// Depends on fcsa_pkg and frustum_cull_sphere_aabb.
module fcsa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [fcsa_pkg::CMD_W-1:0]      command,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            inside_res
);

  import fcsa_pkg::*;

  logic in_xfer;
  logic test_xfer;
  logic load_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign test_xfer = in_xfer && ((command_t'(command) == CMD_SPHERE)
                     || (command_t'(command) == CMD_BOX));
  assign load_xfer = in_xfer && (command_t'(command) == CMD_LOAD);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result dropped or changed while stalled");

  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    test_xfer |=> !in_ready && !$rose(out_valid))
    else $error("test transfer did not occupy the unit");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    load_xfer |=> in_ready)
    else $error("load transfer blocked the input");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a test in progress");

endmodule

bind frustum_cull_sphere_aabb fcsa_checker u_fcsa_checker (.*);
